// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- rtl/lgs_pkg.sv -----
// types and constants of the life generation step block
`default_nettype none

package lgs_pkg;

   localparam int ACTION_W = 2;
   localparam int CELL_W   = 5;

   localparam logic [ACTION_W-1:0] ACT_TOGGLE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CELL_W-1:0]   cell_x;
      logic [CELL_W-1:0]   cell_y;
   } req_type;

   typedef struct packed {
      logic cell_alive;
      logic border_hit;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_ADVANCE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/life_generation_step.sv -----
// life board: toggle, read and advance of a double-buffered b3/s23 cell board
// toggle and read: the row read at the start beat is used in ST_CELL, which registers the result strobe
// advance: one board row read per cycle in ST_ADVANCE, result strobe registered in ST_DRAIN after the last row
// busy rises after the start beat and falls as the result strobe rises
// after reset ST_CLEAR zeroes all 2 * 2**clog2(BOARD_ROWS) board memory words, busy high meanwhile
// results cannot be held off: each strobe lasts exactly one cycle
`default_nettype none

module life_generation_step #(
   parameter int BOARD_COLS = 32,
   parameter int BOARD_ROWS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire lgs_pkg::req_type req_item,
   output logic                 rsp_valid,
   output lgs_pkg::rsp_type     rsp_item
);

   import lgs_pkg::*;

   localparam int ROW_W = $clog2(BOARD_ROWS);
   localparam int AW    = ROW_W + 1;
   localparam int DEPTH = 2 * (2 ** ROW_W);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BOARD_ROWS - 1);

   state_type             state_ff, state_in;
   logic                  half_ff, half_in;
   req_type               req_ff, req_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic                  rdv_ff, rdv_in;
   logic [ROW_W-1:0]      rdi_ff, rdi_in;
   logic [BOARD_COLS-1:0] up_ff, up_in;
   logic [BOARD_COLS-1:0] mid_ff, mid_in;
   logic                  alive_ff, alive_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [BOARD_COLS-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [BOARD_COLS-1:0] rd_data;

   logic [BOARD_COLS-1:0] next_row;
   logic [BOARD_COLS-1:0] cell_shift;
   logic [BOARD_COLS-1:0] next_shift;
   logic [BOARD_COLS-1:0] cell_mask;
   logic [ROW_W-1:0]      y_idx;
   logic [ROW_W-1:0]      wr_row;
   logic                  inner;
   logic                  cell_bit;
   logic                  new_bit;
   logic                  adv_wr;
   logic                  capture;

   lgs_ram #(
      .WIDTH (BOARD_COLS),
      .DEPTH (DEPTH)
   ) u_board (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgs_row_calc #(
      .BOARD_COLS (BOARD_COLS)
   ) u_calc (
      .up_row   (up_ff),
      .mid_row  (mid_ff),
      .dn_row   (rd_data),
      .next_row (next_row)
   );

   assign inner = (req_ff.cell_x != '0) && (32'(req_ff.cell_x) < 32'(BOARD_COLS - 1))
               && (req_ff.cell_y != '0) && (32'(req_ff.cell_y) < 32'(BOARD_ROWS - 1));
   assign y_idx      = ROW_W'(req_ff.cell_y);
   assign cell_shift = rd_data >> req_ff.cell_x;
   assign next_shift = next_row >> req_ff.cell_x;
   assign cell_mask  = BOARD_COLS'(1) << req_ff.cell_x;
   assign cell_bit   = cell_shift[0];
   assign new_bit    = next_shift[0];
   assign wr_row     = rdi_ff - ROW_W'(1);
   assign adv_wr     = rdv_ff && (rdi_ff >= ROW_W'(2));
   assign capture    = adv_wr && inner && (wr_row == y_idx);
   assign up_in      = rdv_ff ? mid_ff : up_ff;
   assign mid_in     = rdv_ff ? rd_data : mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         half_ff      <= 1'b0;
         clr_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         half_ff      <= half_in;
         clr_ff       <= clr_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      row_ff   <= row_in;
      rdi_ff   <= rdi_in;
      up_ff    <= up_in;
      mid_ff   <= mid_in;
      alive_ff <= alive_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      half_in      = half_ff;
      req_in       = req_ff;
      clr_in       = clr_ff;
      row_in       = row_ff;
      rdv_in       = 1'b0;
      rdi_in       = row_ff;
      alive_in     = alive_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = {half_ff, row_ff};

      // row write of a generation sweep into the other half
      if (adv_wr) begin
         wr_en   = 1'b1;
         wr_addr = {~half_ff, wr_row};
         wr_data = next_row;
         if (capture) begin
            alive_in = new_bit;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               alive_in = 1'b0;
               if (req_item.action == ACT_ADVANCE) begin
                  row_in   = '0;
                  state_in = ST_ADVANCE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = {half_ff, ROW_W'(req_item.cell_y)};
                  state_in = ST_CELL;
               end
            end
         end
         ST_CELL: begin
            if ((req_ff.action == ACT_TOGGLE) && inner) begin
               wr_en   = 1'b1;
               wr_addr = {half_ff, y_idx};
               wr_data = rd_data ^ cell_mask;
            end
            rsp_valid_in = 1'b1;
            rsp_in.cell_alive = inner && ((req_ff.action == ACT_TOGGLE) ? !cell_bit : cell_bit);
            rsp_in.border_hit = !inner;
            state_in = ST_IDLE;
         end
         ST_ADVANCE: begin
            rd_en   = 1'b1;
            rd_addr = {half_ff, row_ff};
            rdv_in  = 1'b1;
            rdi_in  = row_ff;
            if (row_ff == LAST_ROW) begin
               state_in = ST_DRAIN;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         ST_DRAIN: begin
            if (rdv_ff && (rdi_ff == LAST_ROW)) begin
               half_in           = ~half_ff;
               rsp_valid_in      = 1'b1;
               rsp_in.cell_alive = capture ? new_bit : alive_ff;
               rsp_in.border_hit = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/lgs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module lgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/lgs_row_calc.sv -----
// next-generation row from three neighboring rows, rule b3/s23
`default_nettype none

module lgs_row_calc #(
   parameter int BOARD_COLS = 32
) (
   input  wire logic [BOARD_COLS-1:0] up_row,
   input  wire logic [BOARD_COLS-1:0] mid_row,
   input  wire logic [BOARD_COLS-1:0] dn_row,
   output logic      [BOARD_COLS-1:0] next_row
);

   assign next_row[0]            = 1'b0;
   assign next_row[BOARD_COLS-1] = 1'b0;

   for (genvar c = 1; c < BOARD_COLS - 1; c++) begin : g_col
      logic [3:0] count;
      assign count = 4'(up_row[c-1]) + 4'(up_row[c]) + 4'(up_row[c+1])
                   + 4'(mid_row[c-1]) + 4'(mid_row[c+1])
                   + 4'(dn_row[c-1]) + 4'(dn_row[c]) + 4'(dn_row[c+1]);
      assign next_row[c] = (count == 4'd3) || (mid_row[c] && (count == 4'd2));
   end

endmodule

`default_nettype wire

// ----- rtl/lgs_checker.sv -----
// port-level checker for the life generation step block, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module lgs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire lgs_pkg::req_type req_item,
   input wire logic             rsp_valid,
   input wire lgs_pkg::rsp_type rsp_item
);

   import lgs_pkg::*;

   logic req_seen;

   assign req_seen = (req_item.action == ACT_TOGGLE) || (req_item.action == ACT_READ)
                  || (req_item.action == ACT_ADVANCE) || 1'b1;

   // an accepted beat keeps the block busy in the next cycle
   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy && req_seen) |=> busy)
   // results never come on consecutive cycles
   `ASSERT_CLK(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   // a border address always reports a dead cell
   `ASSERT_CLK(a_border_dead, clock, reset,
      (rsp_valid && rsp_item.border_hit) |-> !rsp_item.cell_alive)
   // the board clearing pass follows reset
   `ASSERT_ALWAYS(a_reset_busy, clock, $past(reset) |-> (busy && !rsp_valid))

endmodule

bind life_generation_step lgs_checker u_lgs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for life_generation_step: directed and random cell beats checked against a life board model
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lgs_pkg::*;

   localparam int COLS         = 32;
   localparam int ROWS         = 32;
   localparam int RANDOM_BEATS = 1850;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = ROWS + 8;
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CELL_W-1:0]   cell_x;
      logic [CELL_W-1:0]   cell_y;
      bit                  pinned;
      bit                  alive;
      bit                  hit;
   } plan_row_type;

   localparam int PLAN_LEN = 25;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{ACT_READ,    5'd1,  5'd1,  1'b1, 1'b0, 1'b0},
      '{ACT_READ,    5'd30, 5'd30, 1'b1, 1'b0, 1'b0},
      '{ACT_READ,    5'd0,  5'd0,  1'b1, 1'b0, 1'b1},
      '{ACT_TOGGLE,  5'd0,  5'd15, 1'b1, 1'b0, 1'b1},
      '{ACT_TOGGLE,  5'd31, 5'd15, 1'b1, 1'b0, 1'b1},
      '{ACT_TOGGLE,  5'd15, 5'd0,  1'b1, 1'b0, 1'b1},
      '{ACT_TOGGLE,  5'd15, 5'd31, 1'b1, 1'b0, 1'b1},
      '{ACT_TOGGLE,  5'd31, 5'd31, 1'b1, 1'b0, 1'b1},
      '{ACT_TOGGLE,  5'd1,  5'd1,  1'b1, 1'b1, 1'b0},
      '{ACT_TOGGLE,  5'd30, 5'd30, 1'b1, 1'b1, 1'b0},
      '{ACT_TOGGLE,  5'd1,  5'd1,  1'b1, 1'b0, 1'b0},
      '{ACT_SPARE,   5'd30, 5'd30, 1'b1, 1'b1, 1'b0},
      '{ACT_ADVANCE, 5'd0,  5'd0,  1'b1, 1'b0, 1'b0},
      '{ACT_TOGGLE,  5'd5,  5'd4,  1'b1, 1'b1, 1'b0},
      '{ACT_TOGGLE,  5'd5,  5'd5,  1'b1, 1'b1, 1'b0},
      '{ACT_TOGGLE,  5'd5,  5'd6,  1'b1, 1'b1, 1'b0},
      '{ACT_ADVANCE, 5'd4,  5'd5,  1'b0, 1'b0, 1'b0},
      '{ACT_READ,    5'd5,  5'd4,  1'b0, 1'b0, 1'b0},
      '{ACT_ADVANCE, 5'd5,  5'd4,  1'b0, 1'b0, 1'b0},
      '{ACT_TOGGLE,  5'd1,  5'd30, 1'b1, 1'b1, 1'b0},
      '{ACT_TOGGLE,  5'd2,  5'd30, 1'b1, 1'b1, 1'b0},
      '{ACT_TOGGLE,  5'd1,  5'd29, 1'b1, 1'b1, 1'b0},
      '{ACT_TOGGLE,  5'd2,  5'd29, 1'b1, 1'b1, 1'b0},
      '{ACT_ADVANCE, 5'd2,  5'd29, 1'b0, 1'b0, 1'b0},
      '{ACT_READ,    5'd31, 5'd0,  1'b1, 1'b0, 1'b1}
   };

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   bit [COLS-1:0] life_board [2][ROWS];
   bit            life_half;
   rsp_type       expected_cells [$];

   int cycle_count;
   int mismatch_count;
   int checked_count;
   int toggle_count;
   int advance_count;
   int read_count;
   int border_count;
   int cluster_x;
   int cluster_y;

   life_generation_step #(
      .BOARD_COLS(COLS),
      .BOARD_ROWS(ROWS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit life_interior(int x, int y);
      return x >= 1 && x < COLS - 1 && y >= 1 && y < ROWS - 1;
   endfunction

   function automatic void life_advance();
      bit            cur;
      bit            nxt;
      bit [COLS-1:0] row;
      int            n;
      cur = life_half;
      nxt = ~life_half;
      for (int y = 0; y < ROWS; y++) life_board[nxt][y] = '0;
      for (int y = 1; y < ROWS - 1; y++) begin
         row = '0;
         for (int x = 1; x < COLS - 1; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++)
               for (int dx = -1; dx <= 1; dx++)
                  if (dx != 0 || dy != 0) n += int'(life_board[cur][y + dy][x + dx]);
            if (life_board[cur][y][x]) row[x] = (n == 2 || n == 3);
            else row[x] = (n == 3);
         end
         life_board[nxt][y] = row;
      end
      life_half = nxt;
   endfunction

   function automatic rsp_type life_next_result(req_type item);
      rsp_type res;
      int      x;
      int      y;
      bit      inner;
      x = int'(item.cell_x);
      y = int'(item.cell_y);
      inner = life_interior(x, y);
      res = '0;
      case (item.action)
         ACT_TOGGLE: begin
            toggle_count++;
            if (inner) begin
               life_board[life_half][y][x] = ~life_board[life_half][y][x];
               res.cell_alive = life_board[life_half][y][x];
            end else begin
               res.border_hit = 1'b1;
            end
         end
         ACT_ADVANCE: begin
            advance_count++;
            life_advance();
            if (inner) res.cell_alive = life_board[life_half][y][x];
         end
         default: begin
            read_count++;
            if (inner) res.cell_alive = life_board[life_half][y][x];
            else res.border_hit = 1'b1;
         end
      endcase
      if (res.border_hit) border_count++;
      return res;
   endfunction

   // one beat on the request side, with an optional idle gap in front
   task automatic issue_cell_beat(req_type item, bit pinned, rsp_type pinned_rsp, bit may_idle);
      rsp_type predicted;
      if (may_idle && $urandom_range(0, 99) < 17) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      predicted = life_next_result(item);
      expected_cells.push_back(pinned ? pinned_rsp : predicted);
   endtask

   function automatic logic [CELL_W-1:0] pick_coord(int r, int center);
      if (r < 10) return CELL_W'($urandom_range(0, 31));
      if (r < 60) return CELL_W'(center + $urandom_range(0, 4) - 2);
      return CELL_W'($urandom_range(1, 30));
   endfunction

   initial begin
      req_type item;
      rsp_type pinned_rsp;
      int      r;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      life_half = 1'b0;
      cluster_x = 16;
      cluster_y = 16;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         item.action = PLAN[i].action;
         item.cell_x = PLAN[i].cell_x;
         item.cell_y = PLAN[i].cell_y;
         pinned_rsp.cell_alive = PLAN[i].alive;
         pinned_rsp.border_hit = PLAN[i].hit;
         issue_cell_beat(item, PLAN[i].pinned, pinned_rsp, 1'b1);
      end

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) item.action = ACT_TOGGLE;
         else if (r < 75) item.action = ACT_READ;
         else if (r < 93) item.action = ACT_ADVANCE;
         else item.action = ACT_SPARE;
         r = $urandom_range(0, 99);
         item.cell_x = pick_coord(r, cluster_x);
         item.cell_y = pick_coord(r, cluster_y);
         if (item.action == ACT_ADVANCE && $urandom_range(0, 3) == 0) begin
            cluster_x = $urandom_range(3, 28);
            cluster_y = $urandom_range(3, 28);
         end
         // quiet stretch: back-to-back beats
         issue_cell_beat(item, 1'b0, '0, !(i >= 700 && i < 1000));
      end
      start <= 1'b0;

      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d toggles, %0d advances, %0d reads, %0d border beats",
               toggle_count, advance_count, read_count, border_count);
      $display("%0d results checked, %0d mismatches, %0d cycles",
               checked_count, mismatch_count, cycle_count);
      if (mismatch_count == 0 && expected_cells.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         checked_count++;
         if (expected_cells.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: alive %0b border %0b",
                        rsp_item.cell_alive, rsp_item.border_hit);
         end else begin
            want = expected_cells.pop_front();
            if (rsp_item.cell_alive !== want.cell_alive ||
                rsp_item.border_hit !== want.border_hit) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d: expected alive %0b border %0b, got alive %0b border %0b",
                           checked_count, want.cell_alive, want.border_hit,
                           rsp_item.cell_alive, rsp_item.border_hit);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_cells.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule

`default_nettype wire
